// ===== hdl/ntad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntad_pkg
// Shared types, constants and helper functions for the number to ASCII
// digit formatter.
// ----------------------------------------------------------------------------
package ntad_pkg;

  // Widths and limits of the formatter.
  localparam int NUM_W          = 32;
  localparam int LEN_W          = 6;
  localparam int LINE_W         = 3;
  localparam int SCOL_W         = 5;
  localparam int COL_W          = 6;
  localparam int CHAR_W         = 7;
  localparam int MAX_LENGTH     = 32;
  localparam int BCD_DIGITS     = 10;
  localparam int BCD_W          = 4 * BCD_DIGITS;
  localparam int DABBLE_STAGES  = 4;
  localparam int BITS_PER_STAGE = NUM_W / DABBLE_STAGES;

  // ASCII codes used by the formatter.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  // Formatting modes.
  typedef enum logic [1:0] {
    FUNC_UDEC = 2'd0,
    FUNC_SDEC = 2'd1,
    FUNC_HEX  = 2'd2,
    FUNC_BIN  = 2'd3
  } func_e;

  // One number as it travels down the pipeline.
  typedef struct packed {
    func_e                func;
    logic                 neg;
    logic [NUM_W-1:0]     val;
    logic [NUM_W-1:0]     sh;
    logic [BCD_W-1:0]     bcd;
    logic [LEN_W-1:0]     len;
    logic [LINE_W-1:0]    line;
    logic [COL_W-1:0]     col;
  } item_t;

  // One shift-and-add-3 step of the binary to BCD conversion.
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic bit_in);
    logic [BCD_W-1:0] adj;
    logic [3:0]       nib;
    adj = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      nib = bcd[4*i +: 4];
      adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // Digit value to its ASCII character, 0-9 then A-F.
  function automatic logic [CHAR_W-1:0] to_ascii(input logic [3:0] d);
    if (d < 4'd10) begin
      return CHAR_ZERO + {3'b000, d};
    end
    return CHAR_UPPER + {3'b000, d} - 7'd10;
  endfunction

endpackage

// ===== hdl/ntad_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntad_prep
// Entry stage: takes the magnitude in signed mode, saturates the digit
// count and sets up the conversion registers.
// ----------------------------------------------------------------------------
module ntad_prep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [ntad_pkg::NUM_W-1:0]    number_i,
  input  logic [ntad_pkg::LEN_W-1:0]    length_i,
  input  logic [ntad_pkg::LINE_W-1:0]   line_i,
  input  logic [ntad_pkg::SCOL_W-1:0]   start_column_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ntad_pkg::item_t               item_o
);
  import ntad_pkg::*;

  logic  valid_q;
  item_t item_q, item_d;
  func_e func;
  logic  neg;

  // The stage is free when empty or when its beat moves on.
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign item_o      = item_q;

  // Build the item: magnitude, saturated length and starting column.
  always_comb begin
    func          = func_e'(func_i);
    neg           = (func == FUNC_SDEC) && number_i[NUM_W-1];
    item_d.func   = func;
    item_d.neg    = neg;
    item_d.val    = neg ? (~number_i + NUM_W'(1)) : number_i;
    item_d.sh     = item_d.val;
    item_d.bcd    = '0;
    item_d.len    = (length_i > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : length_i;
    item_d.line   = line_i;
    item_d.col    = {1'b0, start_column_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== hdl/ntad_dabble.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntad_dabble
// One binary to BCD conversion stage: shifts eight bits of the magnitude
// into the BCD register with the add-3 adjustment.
// ----------------------------------------------------------------------------
module ntad_dabble (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ntad_pkg::item_t item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ntad_pkg::item_t item_o
);
  import ntad_pkg::*;

  logic             valid_q;
  item_t            item_q, item_d;
  logic [BCD_W-1:0] bcd;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign item_o      = item_q;

  // Eight conversion steps, most significant remaining bit first.
  always_comb begin
    bcd = item_i.bcd;
    for (int j = 0; j < BITS_PER_STAGE; j++) begin
      bcd = dabble_step(bcd, item_i.sh[NUM_W-1-j]);
    end
    item_d     = item_i;
    item_d.bcd = bcd;
    item_d.sh  = item_i.sh << BITS_PER_STAGE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== hdl/ntad_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntad_emit
// Character sequencer: sends the sign in signed mode and then one digit per
// cycle, most significant first, through a registered output.
// ----------------------------------------------------------------------------
module ntad_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ntad_pkg::item_t             item_i,
  output logic                        strobe_o,
  output logic [ntad_pkg::LINE_W-1:0] out_line_o,
  output logic [ntad_pkg::COL_W-1:0]  column_o,
  output logic [ntad_pkg::CHAR_W-1:0] char_code_o,
  output logic                        last_o
);
  import ntad_pkg::*;

  // Sequencer state.
  logic              act_q, act_d;
  logic              sign_q, sign_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [COL_W-1:0]  col_q, col_d;
  item_t             cur_q;

  // Output register.
  logic              strobe_q;
  logic [LINE_W-1:0] line_q;
  logic [COL_W-1:0]  column_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;

  logic              load;
  logic              fin;
  logic [LEN_W-1:0]  e;
  logic [63:0]       bcd_ext;
  logic [3:0]        digit;
  logic [CHAR_W-1:0] code;

  // Digit at exponent e for the current mode; weights past the range give 0.
  always_comb begin
    e       = cnt_q - LEN_W'(1);
    bcd_ext = {{(64-BCD_W){1'b0}}, cur_q.bcd};
    case (cur_q.func)
      FUNC_HEX: digit = (e < LEN_W'(8)) ? cur_q.val[{e[2:0], 2'b00} +: 4] : 4'd0;
      FUNC_BIN: digit = {3'b000, cur_q.val[e[4:0]]};
      default:  digit = (e < LEN_W'(BCD_DIGITS)) ? bcd_ext[{e[3:0], 2'b00} +: 4] : 4'd0;
    endcase
    if (sign_q) begin
      code = cur_q.neg ? CHAR_MINUS : CHAR_PLUS;
      fin  = (cnt_q == '0);
    end else begin
      code = to_ascii(digit);
      fin  = (cnt_q == LEN_W'(1));
    end
  end

  // A new item loads when idle or on the final character of the current one.
  assign in_ready_o = !act_q || fin;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    act_d  = act_q;
    sign_d = sign_q;
    cnt_d  = cnt_q;
    col_d  = col_q;
    if (act_q) begin
      col_d = col_q + COL_W'(1);
      if (fin) begin
        act_d = 1'b0;
      end else if (sign_q) begin
        sign_d = 1'b0;
      end else begin
        cnt_d = cnt_q - LEN_W'(1);
      end
    end
    if (load) begin
      // An item of zero length outside signed mode has no characters and is dropped.
      act_d  = (item_i.func == FUNC_SDEC) || (item_i.len != '0);
      sign_d = (item_i.func == FUNC_SDEC);
      cnt_d  = item_i.len;
      col_d  = item_i.col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      sign_q   <= 1'b0;
      cnt_q    <= '0;
      col_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      act_q    <= act_d;
      sign_q   <= sign_d;
      cnt_q    <= cnt_d;
      col_q    <= col_d;
      strobe_q <= act_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= item_i;
    end
    if (act_q) begin
      line_q   <= cur_q.line;
      column_q <= col_q;
      char_q   <= code;
      last_q   <= fin;
    end
  end

  assign strobe_o    = strobe_q;
  assign out_line_o  = line_q;
  assign column_o    = column_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

// ===== hdl/number_to_ascii_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_ascii_digits
// Formats a 32-bit number as ASCII characters in unsigned decimal, signed
// decimal, uppercase hex or binary, one character per beat.
// ----------------------------------------------------------------------------
// The block sends one character per clock cycle. A number has length digits,
// plus one for the sign in signed mode (eleven characters for a ten-digit
// signed number). The character sequencer sets this rate. A number taken at
// start passes through one entry stage, four binary to BCD stages, the
// sequencer and the output register before its first character appears on
// the ports, and characters of one number come in consecutive cycles with
// last set on the final one. Up to five numbers wait in the pipeline while
// the sequencer works; busy is high when it is full.
// Results cannot be held off: capture every cycle in which strobe_o is high.
// A number of zero length in a mode other than signed decimal gives no
// characters.
// ----------------------------------------------------------------------------
module number_to_ascii_digits (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   func_i,
  input  logic [ntad_pkg::NUM_W-1:0]   number_i,
  input  logic [ntad_pkg::LEN_W-1:0]   length_i,
  input  logic [ntad_pkg::LINE_W-1:0]  line_i,
  input  logic [ntad_pkg::SCOL_W-1:0]  start_column_i,
  output logic                         strobe_o,
  output logic [ntad_pkg::LINE_W-1:0]  out_line_o,
  output logic [ntad_pkg::COL_W-1:0]   column_o,
  output logic [ntad_pkg::CHAR_W-1:0]  char_code_o,
  output logic                         last_o
);
  import ntad_pkg::*;

  logic  prep_ready;
  logic  stg_valid [DABBLE_STAGES+1];
  logic  stg_ready [DABBLE_STAGES+1];
  item_t stg_item  [DABBLE_STAGES+1];

  assign busy = !prep_ready;

  // Entry stage.
  ntad_prep u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (start),
    .in_ready_o     (prep_ready),
    .func_i         (func_i),
    .number_i       (number_i),
    .length_i       (length_i),
    .line_i         (line_i),
    .start_column_i (start_column_i),
    .out_valid_o    (stg_valid[0]),
    .out_ready_i    (stg_ready[0]),
    .item_o         (stg_item[0])
  );

  // Binary to BCD conversion stages.
  for (genvar s = 0; s < DABBLE_STAGES; s++) begin : g_dabble
    ntad_dabble u_dabble (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[s]),
      .in_ready_o  (stg_ready[s]),
      .item_i      (stg_item[s]),
      .out_valid_o (stg_valid[s+1]),
      .out_ready_i (stg_ready[s+1]),
      .item_o      (stg_item[s+1])
    );
  end

  // Character sequencer and output register.
  ntad_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid[DABBLE_STAGES]),
    .in_ready_o  (stg_ready[DABBLE_STAGES]),
    .item_i      (stg_item[DABBLE_STAGES]),
    .strobe_o    (strobe_o),
    .out_line_o  (out_line_o),
    .column_o    (column_o),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

`ifndef ASSERT_OFF
  // Characters of one number leave in consecutive cycles.
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("character stream of a number was interrupted");

  // Within a number the column advances by one per character.
  a_column_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> column_o == COL_W'($past(column_o) + COL_W'(1)))
    else $error("column did not advance by one");

  // Within a number the display line holds.
  a_line_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> $stable(out_line_o))
    else $error("display line changed inside a number");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the number to ASCII digit formatter against an in-bench formatter.
// A short table of directed numbers runs first, some rows with the expected
// characters typed in. Random numbers in every mode follow, with random gaps
// on the start side. Every strobed character is compared field by field
// with the oldest expected character.
// ----------------------------------------------------------------------------
module tb_top;
  import ntad_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYCLES = 12;
  localparam int NUM_RANDOM  = 250;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int NUM_DIR     = 24;
  localparam int TEXT_CHARS  = 16;

  // One character as it leaves the block.
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_beat_t;

  // One number to format; typed rows carry their expected text.
  typedef struct packed {
    func_e                   func;
    logic [NUM_W-1:0]        num;
    logic [LEN_W-1:0]        len;
    logic [LINE_W-1:0]       line;
    logic [SCOL_W-1:0]       scol;
    logic                    typed;
    logic [8*TEXT_CHARS-1:0] text;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [1:0]          func_i;
  logic [NUM_W-1:0]    number_i;
  logic [LEN_W-1:0]    length_i;
  logic [LINE_W-1:0]   line_i;
  logic [SCOL_W-1:0]   start_column_i;
  logic                strobe_o;
  logic [LINE_W-1:0]   out_line_o;
  logic [COL_W-1:0]    column_o;
  logic [CHAR_W-1:0]   char_code_o;
  logic                last_o;

  char_beat_t exp_chars[$];
  int         mismatches = 0;
  int         cycle_cnt;

  // Directed numbers: zero length, extremes, padding and saturation.
  stim_row_t dir_rows [NUM_DIR] = '{
    '{FUNC_UDEC, 32'h0000_0000, 6'd0,  3'd1, 5'd1,  1'b1, ""},
    '{FUNC_SDEC, 32'h0000_0000, 6'd0,  3'd1, 5'd1,  1'b1, "+"},
    '{FUNC_SDEC, 32'h8000_0000, 6'd10, 3'd2, 5'd1,  1'b1, "-2147483648"},
    '{FUNC_UDEC, 32'hFFFF_FFFF, 6'd10, 3'd3, 5'd5,  1'b1, "4294967295"},
    '{FUNC_UDEC, 32'hFFFF_FFFF, 6'd12, 3'd4, 5'd1,  1'b1, "004294967295"},
    '{FUNC_HEX,  32'hDEAD_BEEF, 6'd8,  3'd1, 5'd3,  1'b1, "DEADBEEF"},
    '{FUNC_HEX,  32'hFFFF_FFFF, 6'd10, 3'd2, 5'd7,  1'b1, "00FFFFFFFF"},
    '{FUNC_BIN,  32'h0000_0005, 6'd4,  3'd3, 5'd16, 1'b1, "0101"},
    '{FUNC_SDEC, 32'hFFFF_FFFF, 6'd3,  3'd4, 5'd2,  1'b1, "-001"},
    '{FUNC_SDEC, 32'h7FFF_FFFF, 6'd10, 3'd1, 5'd1,  1'b1, "+2147483647"},
    '{FUNC_HEX,  32'h1234_5678, 6'd0,  3'd2, 5'd4,  1'b1, ""},
    '{FUNC_BIN,  32'hFFFF_FFFF, 6'd0,  3'd3, 5'd9,  1'b1, ""},
    '{FUNC_UDEC, 32'd1234567890, 6'd3, 3'd4, 5'd12, 1'b1, "890"},
    '{FUNC_BIN,  32'hFFFF_FFFF, 6'd63, 3'd7, 5'd31, 1'b0, ""},
    '{FUNC_BIN,  32'h8000_0001, 6'd33, 3'd0, 5'd0,  1'b0, ""},
    '{FUNC_HEX,  32'h0123_ABCD, 6'd32, 3'd5, 5'd16, 1'b0, ""},
    '{FUNC_UDEC, 32'h0000_0000, 6'd32, 3'd6, 5'd31, 1'b0, ""},
    '{FUNC_SDEC, 32'h8000_0000, 6'd63, 3'd7, 5'd31, 1'b0, ""},
    '{FUNC_SDEC, 32'h0000_0000, 6'd1,  3'd0, 5'd0,  1'b0, ""},
    '{FUNC_HEX,  32'hFEDC_BA98, 6'd8,  3'd1, 5'd0,  1'b0, ""},
    '{FUNC_UDEC, 32'd999999999, 6'd10, 3'd2, 5'd20, 1'b0, ""},
    '{FUNC_UDEC, 32'd1000000000, 6'd11, 3'd3, 5'd8, 1'b0, ""},
    '{FUNC_SDEC, 32'hFFFF_FFFF, 6'd32, 3'd4, 5'd30, 1'b0, ""},
    '{FUNC_BIN,  32'hAAAA_AAAA, 6'd32, 3'd2, 5'd10, 1'b0, ""}
  };

  number_to_ascii_digits uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .number_i       (number_i),
    .length_i       (length_i),
    .line_i         (line_i),
    .start_column_i (start_column_i),
    .strobe_o       (strobe_o),
    .out_line_o     (out_line_o),
    .column_o       (column_o),
    .char_code_o    (char_code_o),
    .last_o         (last_o)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Queue one expected character.
  function automatic void add_char(logic [LINE_W-1:0] ln, logic [COL_W-1:0] col,
                                   logic [CHAR_W-1:0] code, logic lst);
    char_beat_t c;
    c.line   = ln;
    c.column = col;
    c.code   = code;
    c.last   = lst;
    exp_chars.push_back(c);
  endfunction

  // Work out the characters of one number and queue them.
  function automatic void format_number(stim_row_t row);
    logic [NUM_W-1:0] mag;
    logic [LEN_W-1:0] n;
    logic [COL_W-1:0] col;
    logic [63:0]      weight;
    logic [3:0]       d;
    int               e;
    n   = (row.len > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : row.len;
    mag = row.num;
    col = {1'b0, row.scol};
    // Signed mode leads with the sign and then works on the magnitude.
    if (row.func == FUNC_SDEC) begin
      add_char(row.line, col, row.num[NUM_W-1] ? CHAR_MINUS : CHAR_PLUS, n == 0);
      if (row.num[NUM_W-1]) mag = -row.num;
      col = col + COL_W'(1);
    end
    for (int i = 0; i < int'(n); i++) begin
      e = int'(n) - 1 - i;
      case (row.func)
        FUNC_HEX: d = (e >= 8) ? 4'd0 : 4'(mag >> (4 * e));
        FUNC_BIN: d = (e >= 32) ? 4'd0 : {3'b000, mag[e % 32]};
        default: begin
          // Positions past the tenth decimal digit are always zero.
          weight = 64'd1;
          repeat (e) weight = weight * 64'd10;
          d = (e >= 10) ? 4'd0 : 4'((64'(mag) / weight) % 64'd10);
        end
      endcase
      add_char(row.line, col + COL_W'(i),
               (d < 4'd10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_UPPER + CHAR_W'(d) - 7'd10,
               e == 0);
    end
  endfunction

  // Present one number, hold it until it is taken, then queue its characters.
  task automatic send_number(input stim_row_t row);
    logic [CHAR_W-1:0] codes[$];
    func_i         <= row.func;
    number_i       <= row.num;
    length_i       <= row.len;
    line_i         <= row.line;
    start_column_i <= row.scol;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (row.typed) begin
      for (int k = TEXT_CHARS - 1; k >= 0; k--) begin
        if (row.text[8*k +: 8] != 8'd0) codes.push_back(row.text[8*k +: CHAR_W]);
      end
      foreach (codes[k]) begin
        add_char(row.line, {1'b0, row.scol} + COL_W'(k), codes[k], k == codes.size() - 1);
      end
    end else begin
      format_number(row);
    end
  endtask

  // Random gap after a beat: mostly none or short, a few long.
  task automatic sender_gap(input bit quiet);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!quiet) begin
      if (r >= 90) gap = $urandom_range(10, 40);
      else if (r >= 50) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random number with a bias toward boundaries and natural lengths.
  function automatic stim_row_t random_row();
    stim_row_t row;
    int        pick;
    row.func  = func_e'($urandom_range(0, 3));
    row.line  = LINE_W'($urandom_range(0, 7));
    row.scol  = SCOL_W'($urandom_range(0, 31));
    row.typed = 1'b0;
    row.text  = '0;
    pick = $urandom_range(0, 9);
    case (pick)
      0: row.num = 32'h0000_0000;
      1: row.num = 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: row.num = 32'h8000_0000 + $urandom_range(0, 1);
      3: row.num = $urandom_range(0, 99);
      4: row.num = 32'd1000000000 - $urandom_range(0, 1);
      5: row.num = -$urandom_range(0, 99);
      default: row.num = $urandom;
    endcase
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      row.len = LEN_W'($urandom_range(0, 63));
    end else if (pick <= 3) begin
      row.len = LEN_W'($urandom_range(1, 12));
    end else begin
      case (row.func)
        FUNC_HEX: row.len = 6'd8;
        FUNC_BIN: row.len = ($urandom_range(0, 3) == 0) ? 6'd32 : 6'($urandom_range(1, 8));
        default:  row.len = 6'd10;
      endcase
    end
    return row;
  endfunction

  // Stimulus.
  initial begin
    bit quiet;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    func_i         <= FUNC_UDEC;
    number_i       <= '0;
    length_i       <= '0;
    line_i         <= '0;
    start_column_i <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_DIR; r++) begin
      send_number(dir_rows[r]);
      sender_gap(1'b0);
    end

    // Stretches with and without gaps on the start side, picked at random.
    quiet = 1'b0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 25 == 0) quiet = $urandom_range(0, 2) == 0;
      send_number(random_row());
      sender_gap(quiet);
    end
    start <= 1'b0;

    while (exp_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[number_to_ascii_digits] OK");
    end else begin
      $display("[number_to_ascii_digits] ERROR");
    end
    $finish;
  end

  // Compare every strobed character with the oldest expected one.
  always @(posedge clk_i) begin
    char_beat_t want;
    if (rst_ni && strobe_o) begin
      if (exp_chars.size() == 0) begin
        $error("unexpected character beat: code %0h column %0d", char_code_o, column_o);
        mismatches++;
      end else begin
        want = exp_chars.pop_front();
        if (out_line_o !== want.line) begin
          $error("out_line: expected %0d, got %0d", want.line, out_line_o);
          mismatches++;
        end
        if (column_o !== want.column) begin
          $error("column: expected %0d, got %0d", want.column, column_o);
          mismatches++;
        end
        if (char_code_o !== want.code) begin
          $error("char_code: expected %0h, got %0h", want.code, char_code_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[number_to_ascii_digits] ERROR");
    $finish;
  end

endmodule
